// ===== hw/rtl/debounced_short_long_press_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the press detector
// Shared wrappers for the concurrent checks on the block ports.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_SHORT_LONG_PRESS_DETECTOR_MACROS_SVH
`define DEBOUNCED_SHORT_LONG_PRESS_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define DSLPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define DSLPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dslpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Press detector package
// Types and constants shared by the press detector modules.
// ----------------------------------------------------------------------------
package dslpd_pkg;

  localparam int unsigned NumLines = 5;

  localparam logic [1:0] CfgDebounce = 2'd0;
  localparam logic [1:0] CfgHoldPeriod = 2'd1;
  localparam logic [1:0] CfgLongLimit = 2'd2;

  localparam logic [15:0] DebounceReset = 16'd50;
  localparam logic [15:0] HoldPeriodReset = 16'd50;
  localparam logic [7:0] LongLimitReset = 8'd19;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] hold_period_ticks;
    logic [7:0]  long_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] key_code;
    logic       is_long;
  } result_t;

endpackage

// ===== hw/rtl/dslpd_core.sv =====
// ----------------------------------------------------------------------------
// Press detector core
// Holds the debounce and hold timers and turns one registered tick into at
// most one press report.
// ----------------------------------------------------------------------------
module dslpd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_valid,
  input  logic [4:0]        tick_levels,
  input  dslpd_pkg::cfg_t   cfg,
  output logic              res_valid,
  output dslpd_pkg::result_t res
);
  import dslpd_pkg::*;

  logic [4:0]  prev_r, prev_nxt;
  logic [2:0]  key_r, key_nxt;
  logic        deb_run_r, deb_run_nxt;
  logic [15:0] deb_rem_r, deb_rem_nxt;
  logic        hold_run_r, hold_run_nxt;
  logic [15:0] per_rem_r, per_rem_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        armed_r, armed_nxt;

  logic [4:0]  rising;
  logic        any_high;
  logic        hold_started;
  logic [15:0] deb_dec;
  logic [15:0] per_dec;
  logic [15:0] deb_len;
  logic [15:0] per_len;

  assign rising   = tick_levels & ~prev_r;
  assign any_high = |tick_levels;
  assign deb_dec  = deb_rem_r - 16'd1;
  assign per_dec  = per_rem_r - 16'd1;
  assign deb_len  = (cfg.debounce_ticks == 16'd0) ? 16'd1 : cfg.debounce_ticks;
  assign per_len  = (cfg.hold_period_ticks == 16'd0) ? 16'd1 : cfg.hold_period_ticks;

  always_comb begin
    prev_nxt     = prev_r;
    key_nxt      = key_r;
    deb_run_nxt  = deb_run_r;
    deb_rem_nxt  = deb_rem_r;
    hold_run_nxt = hold_run_r;
    per_rem_nxt  = per_rem_r;
    count_nxt    = count_r;
    armed_nxt    = armed_r;
    hold_started = 1'b0;
    res_valid    = 1'b0;
    res.key_code = key_r;
    res.is_long  = 1'b0;
    if (tick_valid) begin
      prev_nxt = tick_levels;
      if (rising != 5'd0) begin
        for (int i = 0; i < NumLines; i++) begin
          if (rising[i]) begin
            key_nxt = 3'(i);
          end
        end
        armed_nxt   = 1'b0;
        deb_run_nxt = 1'b1;
        deb_rem_nxt = deb_len;
      end else if (deb_run_r) begin
        deb_rem_nxt = deb_dec;
        if (deb_dec == 16'd0) begin
          deb_run_nxt = 1'b0;
          if (any_high) begin
            armed_nxt    = 1'b1;
            count_nxt    = 8'd0;
            hold_run_nxt = 1'b1;
            per_rem_nxt  = per_len;
            hold_started = 1'b1;
          end
        end
      end
      res.key_code = key_nxt;
      if (hold_run_r && !hold_started) begin
        per_rem_nxt = per_dec;
        if (per_dec == 16'd0) begin
          per_rem_nxt = per_len;
          if (count_r == cfg.long_limit) begin
            count_nxt    = 8'd0;
            hold_run_nxt = 1'b0;
            res_valid    = 1'b1;
            res.is_long  = 1'b1;
          end else if (any_high) begin
            count_nxt = count_r + 8'd1;
          end else if (armed_nxt) begin
            hold_run_nxt = 1'b0;
            res_valid    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      key_r      <= '0;
      deb_run_r  <= 1'b0;
      deb_rem_r  <= '0;
      hold_run_r <= 1'b0;
      per_rem_r  <= '0;
      count_r    <= '0;
      armed_r    <= 1'b0;
    end else begin
      prev_r     <= prev_nxt;
      key_r      <= key_nxt;
      deb_run_r  <= deb_run_nxt;
      deb_rem_r  <= deb_rem_nxt;
      hold_run_r <= hold_run_nxt;
      per_rem_r  <= per_rem_nxt;
      count_r    <= count_nxt;
      armed_r    <= armed_nxt;
    end
  end

endmodule

// ===== hw/rtl/dslpd_outq.sv =====
// ----------------------------------------------------------------------------
// Press detector result queue
// Two-entry output queue that lets ticks keep flowing while a report waits.
// ----------------------------------------------------------------------------
module dslpd_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dslpd_pkg::result_t push_data,
  input  logic               pop,
  output logic [1:0]         count,
  output dslpd_pkg::result_t head
);
  import dslpd_pkg::*;

  result_t    q_r [2];
  result_t    q_nxt [2];
  logic [1:0] count_r, count_nxt;
  logic [1:0] wr_pos;

  assign wr_pos = count_r - {1'b0, pop};
  assign count  = count_r;
  assign head   = q_r[0];

  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (push) begin
      q_nxt[wr_pos[0]] = push_data;
    end
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/debounced_short_long_press_detector.sv =====
// ----------------------------------------------------------------------------
// Debounced short/long press detector
// Watches five joystick lines one tick per item and reports short and long
// presses of the latched key.
//
//   Channel  Direction  Handshake               Payload
//   in_      input      in_valid / in_stall     in_line_levels
//   out_     output     out_valid / out_stall   out_key_code, out_is_long
//   cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One tick is accepted every cycle while the result queue has room.
// A tick is registered, then processed by the core; its report, if any, is
// pushed into the result queue and can be taken from there. The two-entry
// result queue, together with a registered tick, sets when in_stall rises.
// Synchronous reset clears all timers, the queue and the configuration
// registers to their default values. cfg_ready is always high.
// ----------------------------------------------------------------------------
module debounced_short_long_press_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_line_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_key_code,
  output logic        out_is_long,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dslpd_pkg::*;

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic [4:0] s1_levels_r;
  logic       in_take;
  logic       pop;
  logic       res_valid;
  result_t    res;
  result_t    head;
  logic [1:0] q_count;
  logic [2:0] load;

  assign cfg_ready = 1'b1;
  assign out_valid = (q_count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign load      = {1'b0, q_count} + {2'b0, s1_valid_r} - {2'b0, pop};
  assign in_stall  = (load >= 3'd2);
  assign in_take   = in_valid && !in_stall;

  assign out_key_code = head.key_code;
  assign out_is_long  = head.is_long;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks    <= DebounceReset;
      cfg_r.hold_period_ticks <= HoldPeriodReset;
      cfg_r.long_limit        <= LongLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgDebounce:   cfg_r.debounce_ticks    <= cfg_data;
        CfgHoldPeriod: cfg_r.hold_period_ticks <= cfg_data;
        CfgLongLimit:  cfg_r.long_limit        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_levels_r <= in_line_levels;
    end
  end

  dslpd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (s1_valid_r),
    .tick_levels (s1_levels_r),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  dslpd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .count     (q_count),
    .head      (head)
  );

endmodule

// ===== hw/rtl/dslpd_checker.sv =====
// ----------------------------------------------------------------------------
// Press detector port checker
// Checks the port behavior of the press detector over time.
// ----------------------------------------------------------------------------
`include "debounced_short_long_press_detector_macros.svh"

module dslpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_key_code,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  `DSLPD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped")
  `DSLPD_ASSERT_IMP(a_stall_backed, in_stall, out_valid, "input stalled with no result")
  `DSLPD_ASSERT_IMP(a_key_range, out_valid, out_key_code <= 3'd4, "key code out of range")
  `DSLPD_ASSERT_IMP(a_cfg_open, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind debounced_short_long_press_detector dslpd_checker u_dslpd_checker (.*);
